// ===== hw/rtl/mhf_pkg.sv =====
// Package of the multicast hash filter manager: widths, codes, entry type and CRC step.
package mhf_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ADDR_W      = 48;
	localparam int BUCKET_W    = 6;
	localparam int FILTER_W    = 64;
	localparam int CRC_W       = 32;
	localparam int ADDR_BYTES  = ADDR_W / 8;
	localparam int BUCKET_SHIFT = 26;

	localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [CRC_W-1:0] CRC_PRESET = '1;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_DEL = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [BUCKET_W-1:0] bucket;
	} entry_t;

	typedef struct packed {
		logic                done;
		logic [BUCKET_W-1:0] bucket;
	} crc_status_t;

	// One byte of the reflected CRC, least significant bit first.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
		input logic [7:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ data[k]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/mhf_if.sv =====
// Handshake channel interfaces for requests and results of the filter manager.
interface mhf_req_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [mhf_pkg::ADDR_W-1:0] mcast_addr;

	modport source (output valid, output opcode, output mcast_addr, input ready);
	modport sink   (input valid, input opcode, input mcast_addr, output ready);
endinterface

interface mhf_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         status;
	logic                         update_filter;
	logic [mhf_pkg::FILTER_W-1:0] filter_value;

	modport source (output valid, output status, output update_filter, output filter_value,
		input ready);
	modport sink   (input valid, input status, input update_filter, input filter_value,
		output ready);
endinterface

// ===== hw/rtl/multicast_hash_filter_manager_top.sv =====
// Top level of the multicast hash filter manager: sequencer, entry memory and filter.
//
// The block keeps up to TABLE_DEPTH multicast addresses and a 64-bit hash filter. Each
// request (add or delete one address) is handled on its own: the block accepts it, hashes
// the address with a byte-serial CRC-32 unit, then sweeps the entry memory once through
// its single read port, one entry per cycle, to find the address, the other users of its
// bucket and the lowest free slot. After acceptance come hashing, the hand-off of the
// bucket to the scan, TABLE_DEPTH reads, the return of the last read data and the commit.
// The table scan through the one memory read port dominates the time an operation takes.
// A new request is taken as soon as the previous one has committed, even while its result
// still waits in the output register; the next result is held back until the waiting one
// has been taken. The filter and the valid bits clear on reset; memory contents need no
// initialization because an entry is only ever looked at when its valid bit is set.
module multicast_hash_filter_manager_top (
	input  logic          clk,
	input  logic          arst_n,
	mhf_req_if.sink       req,
	mhf_rsp_if.source     rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;

	// Request payload, held for the whole operation.
	logic                         op_q;
	logic [mhf_pkg::ADDR_W-1:0]   addr_q;

	// Hash unit.
	logic                         crc_start;
	mhf_pkg::crc_status_t         crc_stat;
	logic [mhf_pkg::BUCKET_W-1:0] bkt_q;

	// Entry memory and valid bits.
	mhf_pkg::entry_t              mem [mhf_pkg::TABLE_DEPTH];
	logic [mhf_pkg::TABLE_DEPTH-1:0] entry_valid_q;

	// Scan pipeline: issue stage and the cycle the read data returns.
	logic                         issuing_q;
	logic [mhf_pkg::IDX_W-1:0]    rd_idx_q;
	logic                         rd_last;
	logic                         rd_vld_s1;
	logic                         rd_last_s1;
	logic [mhf_pkg::IDX_W-1:0]    rd_idx_s1;
	logic                         vbit_s1;
	mhf_pkg::entry_t              rd_data_s1;
	logic                         addr_eq;

	// Scan findings.
	logic                         match_q;
	logic [mhf_pkg::IDX_W-1:0]    match_idx_q;
	logic                         other_q;
	logic                         free_q;
	logic [mhf_pkg::IDX_W-1:0]    free_idx_q;

	// Commit decisions.
	logic                         commit;
	logic                         mem_we;
	logic                         upd;
	logic                         stat_nxt;
	logic [mhf_pkg::FILTER_W-1:0] bkt_bit;
	logic [mhf_pkg::FILTER_W-1:0] filter_q;
	logic [mhf_pkg::FILTER_W-1:0] filter_nxt;

	// Output register.
	logic                         rsp_valid_q;
	logic                         rsp_status_q;
	logic                         rsp_update_q;

	assign req.ready = (state_q == ST_IDLE);
	assign crc_start = req.valid && req.ready;

	mhf_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crc_start),
		.addr   (req.mcast_addr),
		.stat   (crc_stat)
	);

	always_ff @(posedge clk) begin
		if (crc_start) begin
			op_q   <= req.opcode;
			addr_q <= req.mcast_addr;
		end
	end

	// Read data is used only during the scan and writes happen only at commit, so a write never
	// meets a read whose data is in use and no forwarding path is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[free_idx_q] <= '{addr: addr_q, bucket: bkt_q};
		end
		rd_data_s1 <= mem[rd_idx_q];
	end

	assign rd_last = (rd_idx_q == mhf_pkg::IDX_W'(mhf_pkg::TABLE_DEPTH - 1));
	assign addr_eq = (rd_data_s1.addr == addr_q);

	// The stored bucket of an address is always its own hash, so on a delete the bucket of
	// the matching entry is already known; other users are the valid entries in that
	// bucket whose address differs. On an add with no match this is every user.
	assign commit  = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp.ready);
	assign bkt_bit = mhf_pkg::FILTER_W'(1) << bkt_q;

	always_comb begin
		mem_we     = 1'b0;
		upd        = 1'b0;
		stat_nxt   = mhf_pkg::STATUS_OK;
		filter_nxt = filter_q;
		if (op_q == mhf_pkg::OP_ADD) begin
			if (!match_q) begin
				if (!other_q) begin
					filter_nxt = filter_q | bkt_bit;
					upd        = 1'b1;
				end
				if (free_q) begin
					mem_we = commit;
				end else begin
					// A full table still sets the bucket bit but stores nothing.
					stat_nxt = mhf_pkg::STATUS_FULL;
				end
			end
		end else begin
			if (match_q && !other_q) begin
				filter_nxt = filter_q & ~bkt_bit;
				upd        = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bkt_q         <= '0;
			entry_valid_q <= '0;
			issuing_q     <= 1'b0;
			rd_idx_q      <= '0;
			rd_vld_s1     <= 1'b0;
			rd_last_s1    <= 1'b0;
			rd_idx_s1     <= '0;
			vbit_s1       <= 1'b0;
			match_q       <= 1'b0;
			match_idx_q   <= '0;
			other_q       <= 1'b0;
			free_q        <= 1'b0;
			free_idx_q    <= '0;
			filter_q      <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_status_q  <= 1'b0;
			rsp_update_q  <= 1'b0;
		end else begin
			// A commit in the same cycle loads the next result instead.
			if (rsp_valid_q && rsp.ready && !commit) begin
				rsp_valid_q <= 1'b0;
			end

			rd_vld_s1  <= (state_q == ST_SCAN) && issuing_q;
			rd_last_s1 <= (state_q == ST_SCAN) && issuing_q && rd_last;
			rd_idx_s1  <= rd_idx_q;
			vbit_s1    <= entry_valid_q[rd_idx_q];

			unique case (state_q)
				ST_IDLE: begin
					if (crc_start) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (crc_stat.done) begin
						bkt_q     <= crc_stat.bucket;
						state_q   <= ST_SCAN;
						issuing_q <= 1'b1;
						rd_idx_q  <= '0;
						match_q   <= 1'b0;
						other_q   <= 1'b0;
						free_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						if (rd_last) begin
							issuing_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + mhf_pkg::IDX_W'(1);
						end
					end
					if (rd_vld_s1) begin
						if (vbit_s1 && addr_eq) begin
							match_q     <= 1'b1;
							match_idx_q <= rd_idx_s1;
						end
						if (vbit_s1 && !addr_eq && (rd_data_s1.bucket == bkt_q)) begin
							other_q <= 1'b1;
						end
						if (!vbit_s1 && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
						if (rd_last_s1) begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_COMMIT: begin
					if (commit) begin
						filter_q     <= filter_nxt;
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= stat_nxt;
						rsp_update_q <= upd;
						if (mem_we) begin
							entry_valid_q[free_idx_q] <= 1'b1;
						end
						if ((op_q == mhf_pkg::OP_DEL) && match_q) begin
							entry_valid_q[match_idx_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.update_filter = rsp_update_q;
	assign rsp.filter_value  = filter_q;

endmodule

// ===== hw/rtl/mhf_crc.sv =====
// Byte-serial CRC-32 unit that yields the hash bucket of a multicast address.
module mhf_crc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mhf_pkg::ADDR_W-1:0] addr,
	output mhf_pkg::crc_status_t       stat
);

	logic [mhf_pkg::CRC_W-1:0]  crc_q;
	logic [mhf_pkg::ADDR_W-1:0] data_q;
	logic [2:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'(mhf_pkg::ADDR_BYTES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one address byte per cycle, byte 0 first.
	always_ff @(posedge clk) begin
		if (start) begin
			crc_q  <= mhf_pkg::CRC_PRESET;
			data_q <= addr;
		end else if (busy_q) begin
			crc_q  <= mhf_pkg::crc_byte(crc_q, data_q[7:0]);
			data_q <= data_q >> 8;
		end
	end

	assign stat.done   = done_q;
	assign stat.bucket = crc_q[mhf_pkg::BUCKET_SHIFT +: mhf_pkg::BUCKET_W];

endmodule
